### design/grid_bilinear_interpolator_assert.svh
// Assertion macros shared by the grid interpolator RTL.
// Needs clk and rst_n in the scope of every use; define ASSERT_OFF to drop them.
`ifndef GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define GBI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication
`define GBI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GBI_ASSERT_IMP(lbl, ante, cons)
`define GBI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/gbi_pkg.sv
// Shared types, codes and constants for the grid bilinear interpolator.
// No dependencies.
package gbi_pkg;

  localparam int MAX_LAT_DEF = 64;
  localparam int MAX_LON_DEF = 64;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int IDX_W       = 12;
  localparam int COORD_W     = 32;
  localparam int ELEV_W      = 32;
  localparam int DIV_STEPS   = 34;

  typedef enum logic [1:0] {
    CMD_LD_LAT  = 2'd0,
    CMD_LD_LON  = 2'd1,
    CMD_LD_ELEV = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_LAT_RANGE = 2'd1,
    STAT_NOT_INCR  = 2'd2,
    STAT_IDX_RANGE = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_LAT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LON_COUNT = 1'b1;
  localparam logic [CNT_W-1:0]     COUNT_RST     = 7'd2;

  // Q9.22 degree constants
  localparam logic signed [31:0] DEG90     = 32'sd377487360;
  localparam logic signed [31:0] NEG_DEG90 = -32'sd377487360;
  localparam logic signed [32:0] DEG180    = 33'sd754974720;
  localparam logic signed [32:0] DEG360    = 33'sd1509949440;

  localparam logic signed [31:0] ELEV_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ELEV_MIN = 32'sh8000_0000;

  // Clamp a configured count to [2, maxv]
  function automatic int eff_count(logic [CNT_W-1:0] v, int maxv);
    int c;
    c = int'(v);
    if (c < 2) c = 2;
    else if (c > maxv) c = maxv;
    return c;
  endfunction

endpackage

### design/gbi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/grid_bilinear_interpolator.sv
// Grid bilinear interpolator top level; uses gbi_pkg, gbi_ram and the assert header.
// A query runs two binary searches over the single-read axis RAMs plus a
// 34-step restoring divider.
// One word is in work at a time. Reset is synchronous; memories are not cleared.
`include "grid_bilinear_interpolator_assert.svh"
module grid_bilinear_interpolator #(
  parameter int MAX_LAT = gbi_pkg::MAX_LAT_DEF,
  parameter int MAX_LON = gbi_pkg::MAX_LON_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbi_pkg::CNT_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_command,
  input  logic [gbi_pkg::IDX_W-1:0]          in_index,
  input  logic signed [gbi_pkg::COORD_W-1:0] in_latitude,
  input  logic signed [gbi_pkg::COORD_W-1:0] in_longitude,
  input  logic signed [gbi_pkg::ELEV_W-1:0]  in_elevation_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gbi_pkg::ELEV_W-1:0]  out_elevation_out,
  output logic [1:0]                         out_status
);

  localparam int LAT_AW     = $clog2(MAX_LAT);
  localparam int LON_AW     = $clog2(MAX_LON);
  localparam int AXW        = (LAT_AW > LON_AW) ? LAT_AW : LON_AW;
  localparam int CNW        = AXW + 1;
  localparam int PW         = 2 * CNW;
  localparam int GRID_DEPTH = MAX_LAT * MAX_LON;
  localparam int GAW        = $clog2(GRID_DEPTH);
  localparam logic [3:0] MUL_LAST = 4'd9;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_PREP   = 20'h00002,
    ST_LDCHK  = 20'h00004,
    ST_END1   = 20'h00008,
    ST_END0   = 20'h00010,
    ST_SRD    = 20'h00020,
    ST_SCMP   = 20'h00040,
    ST_CRD0   = 20'h00080,
    ST_CRD1   = 20'h00100,
    ST_CRD2   = 20'h00200,
    ST_GRD0   = 20'h00400,
    ST_GRD1   = 20'h00800,
    ST_GRD2   = 20'h01000,
    ST_GRD3   = 20'h02000,
    ST_GRD4   = 20'h04000,
    ST_MUL    = 20'h08000,
    ST_DIVCHK = 20'h10000,
    ST_DIV    = 20'h20000,
    ST_FIX    = 20'h40000,
    ST_DONE   = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [gbi_pkg::CNT_W-1:0] cfg_lat_r, cfg_lon_r;
  logic [CNW-1:0]            nlat, nlon;

  gbi_pkg::cmd_t             cmd_r;
  logic [gbi_pkg::IDX_W-1:0] idx_r;
  logic signed [31:0]        lat_r, elev_r, w_r, xi_r, yi_r;
  logic signed [32:0]        t_r;
  logic [CNW-1:0]            first_r, cnt_r;
  logic                      sel_lat_r;
  logic [AXW-1:0]            il_r, ia_r;
  logic signed [31:0]        x0_r, x1_r, y0_r, y1_r;
  logic [GAW-1:0]            gaddr_r;
  logic signed [32:0]        wx1_r, wx0_r, wy1_r, wy0_r, dx_r, dy_r;
  logic signed [31:0]        e00_r, e10_r, e01_r, e11_r;
  logic [3:0]                k_r;
  logic signed [65:0]        p_r;
  logic signed [63:0]        a_r, b_r;
  logic [95:0]               acc_r, mag_r;
  logic [63:0]               den_r, rem_r;
  logic                      neg_r;
  logic [33:0]               q_r, bits_r;
  logic [5:0]                dcnt_r;
  logic signed [31:0]        res_r;
  gbi_pkg::status_t          stat_r;
  logic                      out_valid_r;
  logic signed [31:0]        out_elev_r;
  gbi_pkg::status_t          out_stat_r;

  // RAM ports
  logic              lat_we, lon_we, grid_we;
  logic [LAT_AW-1:0] lat_raddr;
  logic [LON_AW-1:0] lon_raddr;
  logic [GAW-1:0]    grid_raddr;
  logic [31:0]       lat_rdata, lon_rdata, grid_rdata, lon_wdata;

  // Working signals
  logic signed [31:0] lat_rd, lon_rd, grid_rd;
  logic               lat_bad, idx_lat_bad, idx_lon_bad, grid_bad;
  logic signed [32:0] tt, wsum;
  logic signed [31:0] wrap_w;
  logic [CNW-1:0]     half, mid, nsel, ci;
  logic signed [31:0] srch_rd, srch_key, prev_rd, load_val;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [95:0]        p_ext, p_sh;
  logic [63:0]        rem_sh;
  logic               rem_ge;
  logic [34:0]        qq;
  logic               fin;
  gbi_pkg::status_t   fin_stat;
  logic signed [31:0] fin_res;

  assign nlat = CNW'(gbi_pkg::eff_count(cfg_lat_r, MAX_LAT));
  assign nlon = CNW'(gbi_pkg::eff_count(cfg_lon_r, MAX_LON));

  assign lat_rd  = lat_rdata;
  assign lon_rd  = lon_rdata;
  assign grid_rd = grid_rdata;

  // Range checks on the held word
  assign lat_bad     = (lat_r < gbi_pkg::NEG_DEG90) || (lat_r > gbi_pkg::DEG90);
  assign idx_lat_bad = 32'(idx_r) >= 32'(nlat);
  assign idx_lon_bad = 32'(idx_r) >= 32'(nlon);
  assign grid_bad    = (32'(idx_r) >= 32'(PW'(nlat) * PW'(nlon))) ||
                       (32'(idx_r) >= 32'(GRID_DEPTH));

  // Wrap longitude into [-180,180)
  always_comb begin
    if (t_r < 33'sd0) tt = t_r + gbi_pkg::DEG360;
    else if (t_r >= gbi_pkg::DEG360) tt = t_r - gbi_pkg::DEG360;
    else tt = t_r;
    wsum   = tt - gbi_pkg::DEG180;
    wrap_w = wsum[31:0];
  end

  // Binary search helpers
  assign half     = cnt_r >> 1;
  assign mid      = first_r + half;
  assign nsel     = sel_lat_r ? nlat : nlon;
  assign srch_rd  = sel_lat_r ? lat_rd : lon_rd;
  assign srch_key = sel_lat_r ? yi_r : xi_r;
  always_comb begin
    if (first_r == '0) ci = '0;
    else if (first_r >= nsel) ci = nsel - CNW'(2);
    else ci = first_r - CNW'(1);
  end

  assign prev_rd  = (cmd_r == gbi_pkg::CMD_LD_LAT) ? lat_rd : lon_rd;
  assign load_val = (cmd_r == gbi_pkg::CMD_LD_LAT) ? lat_r : w_r;
  assign lon_wdata = (state_r == ST_PREP) ? wrap_w : w_r;

  // Shared multiplier operand select
  always_comb begin
    unique case (k_r)
      4'd0:    begin mul_a = wx1_r; mul_b = {e00_r[31], e00_r}; end
      4'd1:    begin mul_a = wx0_r; mul_b = {e10_r[31], e10_r}; end
      4'd2:    begin mul_a = wx1_r; mul_b = {e01_r[31], e01_r}; end
      4'd3:    begin mul_a = wx0_r; mul_b = {e11_r[31], e11_r}; end
      4'd4:    begin mul_a = wy1_r; mul_b = {1'b0, a_r[31:0]}; end
      4'd5:    begin mul_a = wy1_r; mul_b = {a_r[63], a_r[63:32]}; end
      4'd6:    begin mul_a = wy0_r; mul_b = {1'b0, b_r[31:0]}; end
      4'd7:    begin mul_a = wy0_r; mul_b = {b_r[63], b_r[63:32]}; end
      4'd8:    begin mul_a = dx_r;  mul_b = dy_r; end
      default: begin mul_a = '0;    mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
    p_ext = {{30{p_r[65]}}, p_r};
    p_sh  = {p_ext[63:0], 32'b0};
  end

  // Divider step and final rounding
  assign rem_sh = {rem_r[62:0], bits_r[33]};
  assign rem_ge = rem_sh >= den_r;
  assign qq     = {1'b0, q_r} + {34'b0, (rem_r != '0)};

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    lat_we     = 1'b0;
    lon_we     = 1'b0;
    grid_we    = 1'b0;
    lat_raddr  = '0;
    lon_raddr  = '0;
    grid_raddr = gaddr_r;
    fin        = 1'b0;
    fin_stat   = gbi_pkg::STAT_OK;
    fin_res    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        unique case (cmd_r)
          gbi_pkg::CMD_LD_LAT: begin
            lat_raddr = LAT_AW'(idx_r - 12'd1);
            if (idx_lat_bad) begin
              fin = 1'b1; fin_stat = gbi_pkg::STAT_IDX_RANGE;
            end else if (lat_bad) begin
              fin = 1'b1; fin_stat = gbi_pkg::STAT_LAT_RANGE;
            end else if (idx_r == '0) begin
              lat_we = 1'b1; fin = 1'b1;
            end else begin
              state_nxt = ST_LDCHK;
            end
          end
          gbi_pkg::CMD_LD_LON: begin
            lon_raddr = LON_AW'(idx_r - 12'd1);
            if (idx_lon_bad) begin
              fin = 1'b1; fin_stat = gbi_pkg::STAT_IDX_RANGE;
            end else if (idx_r == '0) begin
              lon_we = 1'b1; fin = 1'b1;
            end else begin
              state_nxt = ST_LDCHK;
            end
          end
          gbi_pkg::CMD_LD_ELEV: begin
            fin = 1'b1;
            if (grid_bad) fin_stat = gbi_pkg::STAT_IDX_RANGE;
            else grid_we = 1'b1;
          end
          gbi_pkg::CMD_QUERY: begin
            lat_raddr = LAT_AW'(nlat - CNW'(1));
            lon_raddr = LON_AW'(nlon - CNW'(1));
            if (lat_bad) begin
              fin = 1'b1; fin_stat = gbi_pkg::STAT_LAT_RANGE;
            end else begin
              state_nxt = ST_END1;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      ST_LDCHK: begin
        if (cmd_r == gbi_pkg::CMD_LD_LAT) lat_we = 1'b1;
        else lon_we = 1'b1;
        fin = 1'b1;
        if (prev_rd >= load_val) fin_stat = gbi_pkg::STAT_NOT_INCR;
      end
      ST_END1: state_nxt = ST_END0;
      ST_END0: state_nxt = ST_SRD;
      ST_SRD: begin
        lat_raddr = LAT_AW'(mid);
        lon_raddr = LON_AW'(mid);
        if (cnt_r == '0) begin
          if (sel_lat_r) state_nxt = ST_CRD0;
        end else begin
          state_nxt = ST_SCMP;
        end
      end
      ST_SCMP: state_nxt = ST_SRD;
      ST_CRD0: begin
        lat_raddr = LAT_AW'(ia_r);
        lon_raddr = LON_AW'(il_r);
        state_nxt = ST_CRD1;
      end
      ST_CRD1: begin
        lat_raddr = LAT_AW'(ia_r + AXW'(1));
        lon_raddr = LON_AW'(il_r + AXW'(1));
        state_nxt = ST_CRD2;
      end
      ST_CRD2: state_nxt = ST_GRD0;
      ST_GRD0: begin
        if ((x1_r <= x0_r) || (y1_r <= y0_r)) begin
          fin = 1'b1; fin_stat = gbi_pkg::STAT_NOT_INCR;
        end else begin
          state_nxt = ST_GRD1;
        end
      end
      ST_GRD1: begin
        grid_raddr = gaddr_r + GAW'(1);
        state_nxt  = ST_GRD2;
      end
      ST_GRD2: begin
        grid_raddr = gaddr_r + GAW'(nlon);
        state_nxt  = ST_GRD3;
      end
      ST_GRD3: begin
        grid_raddr = gaddr_r + GAW'(nlon + CNW'(1));
        state_nxt  = ST_GRD4;
      end
      ST_GRD4: state_nxt = ST_MUL;
      ST_MUL: begin
        if (k_r == MUL_LAST) state_nxt = ST_DIVCHK;
      end
      ST_DIVCHK: begin
        if ({2'b0, mag_r[95:34]} >= den_r) begin
          fin     = 1'b1;
          fin_res = neg_r ? gbi_pkg::ELEV_MIN : gbi_pkg::ELEV_MAX;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_r == 6'd1) state_nxt = ST_FIX;
      end
      ST_FIX: begin
        fin = 1'b1;
        if (!neg_r) begin
          fin_res = (q_r > 34'h0_7FFF_FFFF) ? gbi_pkg::ELEV_MAX : q_r[31:0];
        end else begin
          fin_res = (qq > 35'h0_8000_0000) ? gbi_pkg::ELEV_MIN : (~qq[31:0] + 32'd1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (fin) state_nxt = ST_DONE;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_lat_r   <= gbi_pkg::COUNT_RST;
      cfg_lon_r   <= gbi_pkg::COUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gbi_pkg::REG_LAT_COUNT: cfg_lat_r <= cfg_data;
          gbi_pkg::REG_LON_COUNT: cfg_lon_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r  <= gbi_pkg::cmd_t'(in_command);
          idx_r  <= in_index;
          lat_r  <= in_latitude;
          elev_r <= in_elevation_in;
          t_r    <= {in_longitude[31], in_longitude} + gbi_pkg::DEG180;
        end
      end
      ST_PREP: w_r <= wrap_w;
      ST_END1: begin
        xi_r <= (w_r > lon_rd) ? lon_rd : w_r;
        yi_r <= (lat_r > lat_rd) ? lat_rd : lat_r;
      end
      ST_END0: begin
        xi_r      <= (xi_r < lon_rd) ? lon_rd : xi_r;
        yi_r      <= (yi_r < lat_rd) ? lat_rd : yi_r;
        first_r   <= '0;
        cnt_r     <= nlon;
        sel_lat_r <= 1'b0;
      end
      ST_SRD: begin
        if (cnt_r == '0) begin
          if (!sel_lat_r) begin
            il_r      <= AXW'(ci);
            sel_lat_r <= 1'b1;
            first_r   <= '0;
            cnt_r     <= nlat;
          end else begin
            ia_r <= AXW'(ci);
          end
        end
      end
      ST_SCMP: begin
        // Narrow the lower-bound window
        if (srch_rd < srch_key) begin
          first_r <= mid + CNW'(1);
          cnt_r   <= cnt_r - half - CNW'(1);
        end else begin
          cnt_r <= half;
        end
      end
      ST_CRD1: begin
        x0_r <= lon_rd;
        y0_r <= lat_rd;
      end
      ST_CRD2: begin
        x1_r    <= lon_rd;
        y1_r    <= lat_rd;
        gaddr_r <= GAW'(PW'(ia_r) * PW'(nlon) + PW'(il_r));
      end
      ST_GRD0: begin
        wx1_r <= {x1_r[31], x1_r} - {xi_r[31], xi_r};
        wx0_r <= {xi_r[31], xi_r} - {x0_r[31], x0_r};
        wy1_r <= {y1_r[31], y1_r} - {yi_r[31], yi_r};
        wy0_r <= {yi_r[31], yi_r} - {y0_r[31], y0_r};
        dx_r  <= {x1_r[31], x1_r} - {x0_r[31], x0_r};
        dy_r  <= {y1_r[31], y1_r} - {y0_r[31], y0_r};
      end
      ST_GRD1: e00_r <= grid_rd;
      ST_GRD2: e10_r <= grid_rd;
      ST_GRD3: e01_r <= grid_rd;
      ST_GRD4: begin
        e11_r <= grid_rd;
        k_r   <= '0;
      end
      ST_MUL: begin
        // Product of the previous step folds in here
        p_r <= mul_p;
        k_r <= k_r + 4'd1;
        unique case (k_r)
          4'd1: a_r <= p_r[63:0];
          4'd2: a_r <= a_r + p_r[63:0];
          4'd3: b_r <= p_r[63:0];
          4'd4: b_r <= b_r + p_r[63:0];
          4'd5: acc_r <= p_ext;
          4'd6: acc_r <= acc_r + p_sh;
          4'd7: acc_r <= acc_r + p_ext;
          4'd8: acc_r <= acc_r + p_sh;
          4'd9: begin
            den_r <= p_r[63:0];
            neg_r <= acc_r[95];
            mag_r <= acc_r[95] ? (~acc_r + 96'd1) : acc_r;
          end
          default: ;
        endcase
      end
      ST_DIVCHK: begin
        rem_r  <= {2'b0, mag_r[95:34]};
        bits_r <= mag_r[33:0];
        q_r    <= '0;
        dcnt_r <= 6'(gbi_pkg::DIV_STEPS);
      end
      ST_DIV: begin
        rem_r  <= rem_ge ? (rem_sh - den_r) : rem_sh;
        q_r    <= {q_r[32:0], rem_ge};
        bits_r <= {bits_r[32:0], 1'b0};
        dcnt_r <= dcnt_r - 6'd1;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_elev_r <= res_r;
          out_stat_r <= stat_r;
        end
      end
      default: ;
    endcase
    if (fin) begin
      res_r  <= fin_res;
      stat_r <= fin_stat;
    end
  end

  // Axis and grid storage
  gbi_ram #(.WIDTH(32), .DEPTH(MAX_LAT)) u_lat_ram (
    .clk(clk), .we(lat_we), .waddr(LAT_AW'(idx_r)), .wdata(lat_r),
    .raddr(lat_raddr), .rdata(lat_rdata)
  );

  gbi_ram #(.WIDTH(32), .DEPTH(MAX_LON)) u_lon_ram (
    .clk(clk), .we(lon_we), .waddr(LON_AW'(idx_r)), .wdata(lon_wdata),
    .raddr(lon_raddr), .rdata(lon_rdata)
  );

  gbi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid_ram (
    .clk(clk), .we(grid_we), .waddr(GAW'(idx_r)), .wdata(elev_r),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_elevation_out = out_elev_r;
  assign out_status        = out_stat_r;

  // Checks
  `GBI_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE)
  `GBI_ASSERT_NXT(a_done_shows, state_r == ST_DONE && (!out_valid_r || out_ready), out_valid_r)
  `GBI_ASSERT_IMP(a_div_den, state_r == ST_DIV, den_r != '0)
  `GBI_ASSERT_IMP(a_srch_cnt, state_r == ST_SCMP, cnt_r != '0)

endmodule
